// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the hash core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold whenever ante holds
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== rtl/core/mur_pkg.sv =====
// Shared constants and types of the MurmurHash64A stream core.
package mur_pkg;

	localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
	localparam int unsigned MUR_R = 47;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_TAIL = 2'd1,
		KIND_FULL = 2'd2
	} mur_kind_t;

	// one classified word, as kept in the front queue
	typedef struct packed {
		logic        first;
		logic [30:0] total_length;
		logic [63:0] word;
		mur_kind_t   kind;
		logic        last;
	} mur_item_t;

	// front queue head as seen by the back end
	typedef struct packed {
		logic      valid;
		mur_item_t item;
	} mur_head_t;

endpackage

// ===== rtl/core/mur_mul.sv =====
// Multiply by the hash constant, mod 2^64, on one shared 32x32 multiplier.
`include "assert_macros.svh"
module mur_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] res
);
	import mur_pkg::*;

	logic [1:0]  phase_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod;

	// phase 1: lo*lo, phase 2: hi*lo cross term, phase 3: lo*hi cross term
	always_comb begin
		op_x = (phase_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		op_y = (phase_q == 2'd3) ? MUR_M[63:32] : MUR_M[31:0];
		prod = 64'(op_x) * 64'(op_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == 2'd3);
			if (start) begin
				phase_q <= 2'd1;
			end else if (phase_q != 2'd0) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end
		if (phase_q == 2'd1) begin
			acc_q <= prod;
		end else if (phase_q != 2'd0) begin
			acc_q[63:32] <= acc_q[63:32] + prod[31:0];
		end
	end

	assign done = done_q;
	assign res  = acc_q;

	`ASSERT_IMPLIES(a_start_idle, clk, arst_n, start, phase_q == 2'd0)
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done_q, phase_q == 2'd0)

endmodule

// ===== rtl/core/mur_front.sv =====
// Front end: accepts words, masks tail bytes, classifies and queues them.
`include "assert_macros.svh"
module mur_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              first,
	input  logic [30:0]       total_length,
	input  logic [63:0]       data_word,
	input  logic [3:0]        valid_bytes,
	input  logic              last,
	output mur_pkg::mur_head_t head,
	input  logic              head_pop
);
	import mur_pkg::*;

	mur_item_t   q_mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	mur_item_t   cls;

	always_comb begin
		cls.first        = first;
		cls.total_length = total_length;
		cls.last         = last;
		cls.word         = data_word;
		if (valid_bytes == 4'd0) begin
			cls.kind = KIND_NONE;
		end else if (valid_bytes >= 4'd8) begin
			cls.kind = KIND_FULL;
		end else begin
			cls.kind = KIND_TAIL;
			for (int i = 0; i < 8; i++) begin
				if (4'(i) >= valid_bytes) begin
					cls.word[i*8 +: 8] = 8'h00;
				end
			end
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, head_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = q_mem_q[rd_ptr_q];

	`ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, head_pop, cnt_q != 2'd0)
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3)

endmodule

// ===== rtl/core/mur_back.sv =====
// Back end: sequences the hash recurrence on the shared multiplier and queues results.
`include "assert_macros.svh"
module mur_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       seed,
	input  mur_pkg::mur_head_t head,
	output logic              head_pop,
	output logic              empty,
	input  logic              pop,
	output logic [63:0]       hash
);
	import mur_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INIT = 6'b000010,
		S_K1   = 6'b000100,
		S_K2   = 6'b001000,
		S_HM   = 6'b010000,
		S_FN   = 6'b100000
	} mur_state_t;

	mur_state_t  state_q, state_d;
	mur_item_t   ent_q;
	mur_item_t   cur;
	logic [63:0] h_q, h_d;
	logic [63:0] hb;
	logic        do_mix;
	logic        do_end;
	logic        mul_start;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] mul_res;
	logic        out_push;
	logic [63:0] out_data;
	logic [63:0] oq_q [2];
	logic        owr_q;
	logic        ord_q;
	logic [1:0]  ocnt_q;
	logic        out_pop;

	mur_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.done   (mul_done),
		.res    (mul_res)
	);

	assign cur = (state_q == S_IDLE) ? head.item : ent_q;

	always_comb begin
		state_d   = state_q;
		h_d       = h_q;
		hb        = h_q;
		do_mix    = 1'b0;
		do_end    = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		out_push  = 1'b0;
		out_data  = mul_res ^ (mul_res >> MUR_R);
		head_pop  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// result slot is reserved before a word is taken
				if (head.valid && ocnt_q != 2'd2) begin
					head_pop = 1'b1;
					if (head.item.first) begin
						mul_start = 1'b1;
						mul_a     = {33'd0, head.item.total_length};
						state_d   = S_INIT;
					end else begin
						do_mix = 1'b1;
					end
				end
			end
			S_INIT: begin
				if (mul_done) begin
					hb     = seed ^ mul_res;
					do_mix = 1'b1;
				end
			end
			S_K1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_res ^ (mul_res >> MUR_R);
					state_d   = S_K2;
				end
			end
			S_K2: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = h_q ^ mul_res;
					state_d   = S_HM;
				end
			end
			S_HM: begin
				if (mul_done) begin
					hb     = mul_res;
					do_end = 1'b1;
				end
			end
			S_FN: begin
				if (mul_done) begin
					out_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (do_mix) begin
			h_d = hb;
			case (cur.kind)
				KIND_FULL: begin
					mul_start = 1'b1;
					mul_a     = cur.word;
					state_d   = S_K1;
				end
				KIND_TAIL: begin
					mul_start = 1'b1;
					mul_a     = hb ^ cur.word;
					state_d   = S_HM;
				end
				default: do_end = 1'b1;
			endcase
		end

		if (do_end) begin
			h_d = hb;
			if (cur.last) begin
				mul_start = 1'b1;
				mul_a     = hb ^ (hb >> MUR_R);
				state_d   = S_FN;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	assign out_pop = pop && (ocnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q     <= 64'd0;
			owr_q   <= 1'b0;
			ord_q   <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			h_q     <= h_d;
			if (out_push) begin
				owr_q <= ~owr_q;
			end
			if (out_pop) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, out_push} - {1'b0, out_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			ent_q <= head.item;
		end
		if (out_push) begin
			oq_q[owr_q] <= out_data;
		end
	end

	assign empty = (ocnt_q == 2'd0);
	assign hash  = oq_q[ord_q];

	`ASSERT_IMPLIES(a_done_busy, clk, arst_n, mul_done, state_q != S_IDLE)
	`ASSERT_IMPLIES(a_push_room, clk, arst_n, out_push, ocnt_q != 2'd2)
	`ASSERT_IMPLIES(a_pop_idle, clk, arst_n, head_pop, state_q == S_IDLE)

endmodule

// ===== rtl/core/murmur64a_stream_hash.sv =====
// MurmurHash64A stream hasher top level: seed register, front queue, back sequencer.
// Each 64-bit multiply runs on one shared 32x32 multiplier (3 partial products).
// Per word: three multiplies for 8 valid bytes, one for a tail, none with no valid bytes;
// a first word adds one multiply, a last word adds one for finalization.
// arst_n clears the queues, the sequencer, the running hash and the seed to zero.
module murmur64a_stream_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	input  logic        push,
	output logic        full,
	input  logic        first,
	input  logic [30:0] total_length,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash
);
	import mur_pkg::*;

	logic [63:0] seed_q;
	mur_head_t   head;
	logic        head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 64'd0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	mur_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.first        (first),
		.total_length (total_length),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.last         (last),
		.head         (head),
		.head_pop     (head_pop)
	);

	mur_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.seed     (seed_q),
		.head     (head),
		.head_pop (head_pop),
		.empty    (empty),
		.pop      (pop),
		.hash     (hash)
	);

endmodule
